[rtl/sssc_pkg.sv]
`default_nettype none

package sssc_pkg;

  typedef enum logic [1:0] {
    MODE_RAMP   = 2'd0,
    MODE_SYNC   = 2'd1,
    MODE_CLOSED = 2'd2
  } mode_t;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam int REG_IDX_BITS = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_INITIAL_PERIOD = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_RAMP_STEP      = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_MIN_PERIOD     = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_SYNC_PERIOD    = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_BEMF_THRESHOLD = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_DRIVE_COMPARE  = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_SYNC_CROSSINGS = 3'd6;

  localparam int DEF_INITIAL_PERIOD = 142851;
  localparam int DEF_MIN_PERIOD     = 3000;
  localparam int DEF_SYNC_PERIOD    = 9000;
  localparam int DEF_BEMF_THRESHOLD = 1343;
  localparam logic [15:0] DEF_RAMP_STEP      = 16'd2500;
  localparam logic [4:0]  DEF_DRIVE_COMPARE  = 5'd14;
  localparam logic [3:0]  DEF_SYNC_CROSSINGS = 4'd5;

  localparam logic [4:0] PWM_TOP   = 5'd19;
  localparam logic [3:0] COUNT_MAX = 4'd15;
  localparam logic [2:0] LAST_STAGE = 3'd5;

  localparam logic [1:0] PHASE_U = 2'd0;
  localparam logic [1:0] PHASE_V = 2'd1;
  localparam logic [1:0] PHASE_W = 2'd2;

  localparam int QDEPTH = 2;
  localparam int QPTW   = $clog2(QDEPTH);

  typedef struct packed {
    logic       tick;
    logic [2:0] at_or_above;
  } qent_t;

  typedef struct packed {
    logic [1:0] high;
    logic [1:0] low;
    logic [1:0] float_ph;
  } stage_t;

  function automatic stage_t stage_lookup(input logic [2:0] st);
    stage_t s;
    case (st)
      3'd1:    s = '{high: PHASE_U, low: PHASE_W, float_ph: PHASE_V};
      3'd2:    s = '{high: PHASE_V, low: PHASE_W, float_ph: PHASE_U};
      3'd3:    s = '{high: PHASE_V, low: PHASE_U, float_ph: PHASE_W};
      3'd4:    s = '{high: PHASE_W, low: PHASE_U, float_ph: PHASE_V};
      3'd5:    s = '{high: PHASE_W, low: PHASE_V, float_ph: PHASE_U};
      default: s = '{high: PHASE_U, low: PHASE_V, float_ph: PHASE_W};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/sssc_front.sv]
`default_nettype none

module sssc_front #(
  parameter int ADC_BITS = 12
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                req_type,
  input  wire logic [ADC_BITS-1:0] bemf_u_raw,
  input  wire logic [ADC_BITS-1:0] bemf_v_raw,
  input  wire logic [ADC_BITS-1:0] bemf_w_raw,
  input  wire logic [ADC_BITS-1:0] bemf_threshold,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output sssc_pkg::qent_t          q_entry
);
  import sssc_pkg::*;

  logic  vld;
  qent_t ent;

  assign in_ready = !vld || q_ready;
  assign q_valid  = vld;
  assign q_entry  = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  // compare all three phases now; the back end picks the floating one
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ent.tick           <= (req_type == REQ_TICK);
      ent.at_or_above[0] <= (bemf_u_raw >= bemf_threshold);
      ent.at_or_above[1] <= (bemf_v_raw >= bemf_threshold);
      ent.at_or_above[2] <= (bemf_w_raw >= bemf_threshold);
    end
  end

endmodule

`default_nettype wire

[rtl/sssc_queue.sv]
`default_nettype none

module sssc_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sssc_pkg::qent_t  in_entry,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sssc_pkg::qent_t       out_entry
);
  import sssc_pkg::*;

  qent_t           mem [QDEPTH];
  logic [QPTW-1:0] wr_ptr;
  logic [QPTW-1:0] rd_ptr;
  logic [QPTW:0]   count;
  logic            push;
  logic            pop;

  assign in_ready  = (count != (QPTW+1)'(QDEPTH));
  assign out_valid = (count != '0);
  assign out_entry = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sssc_back.sv]
`default_nettype none

module sssc_back #(
  parameter int PERIOD_BITS = 18
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [PERIOD_BITS-1:0] min_period,
  input  wire logic [PERIOD_BITS-1:0] sync_period,
  input  wire logic [15:0]            ramp_step,
  input  wire logic [4:0]             drive_compare,
  input  wire logic [3:0]             sync_crossings,
  input  wire logic                   q_valid,
  output logic                        q_ready,
  input  wire sssc_pkg::qent_t        q_entry,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        commutated,
  output logic [1:0]                  high_phase,
  output logic [1:0]                  low_phase,
  output logic [1:0]                  float_phase,
  output logic [4:0]                  duty_out,
  output logic [PERIOD_BITS-1:0]      reload_value,
  output logic                        reload_written,
  output sssc_pkg::mode_t             mode_out,
  output logic                        crossing_seen
);
  import sssc_pkg::*;

  localparam int CW = (PERIOD_BITS > 16) ? PERIOD_BITS : 16;
  localparam logic [PERIOD_BITS-1:0] INIT_RST = PERIOD_BITS'(DEF_INITIAL_PERIOD);
  localparam logic [PERIOD_BITS-1:0] RELOAD_RST =
    (INIT_RST == '0) ? '0 : INIT_RST - 1'b1;

  logic [2:0]             next_stage, next_stage_next;
  mode_t                  mode, mode_next;
  logic [PERIOD_BITS-1:0] ramp_period, ramp_period_next;
  logic [PERIOD_BITS-1:0] timer_reload, timer_reload_next;
  logic [1:0]             floating_now, floating_now_next;
  logic                   crossing_flag, crossing_flag_next;
  logic [3:0]             sync_count, sync_count_next;

  logic                   pop;
  logic [2:0]             st;
  stage_t                 ph;
  logic [4:0]             duty_sat;
  logic [CW-1:0]          ramp_x, step_x;
  logic [PERIOD_BITS-1:0] ramp_short, ramp_dec;
  logic [PERIOD_BITS-1:0] half, np, np_dec;
  logic [3:0]             count_inc;
  logic                   sel_ge, hit;

  logic                   r_commutated, r_written, r_seen;
  logic [1:0]             r_high, r_low;
  logic [4:0]             r_duty;

  assign pop     = q_valid && (!out_valid || out_ready);
  assign q_ready = !out_valid || out_ready;

  assign st       = (next_stage > LAST_STAGE) ? 3'd0 : next_stage;
  assign ph       = stage_lookup(st);
  assign duty_sat = (drive_compare > PWM_TOP) ? PWM_TOP : drive_compare;

  assign ramp_x     = CW'(ramp_period);
  assign step_x     = CW'(ramp_step);
  assign ramp_short = (ramp_period > min_period)
                    ? ((ramp_x > step_x) ? PERIOD_BITS'(ramp_x - step_x) : '0)
                    : ramp_period;
  assign ramp_dec   = (ramp_short == '0) ? '0 : ramp_short - 1'b1;

  assign half   = timer_reload >> 1;
  assign np     = (half < min_period) ? min_period : half;
  assign np_dec = (np == '0) ? '0 : np - 1'b1;

  assign count_inc = (crossing_flag && sync_count != COUNT_MAX)
                   ? sync_count + 1'b1 : sync_count;

  always_comb begin
    case (floating_now)
      PHASE_U: sel_ge = q_entry.at_or_above[0];
      PHASE_V: sel_ge = q_entry.at_or_above[1];
      default: sel_ge = q_entry.at_or_above[2];
    endcase
  end

  // even stage counter: rising edge expected, odd: falling
  assign hit = next_stage[0] ? !sel_ge : sel_ge;

  always_comb begin
    next_stage_next    = next_stage;
    mode_next          = mode;
    ramp_period_next   = ramp_period;
    timer_reload_next  = timer_reload;
    floating_now_next  = floating_now;
    crossing_flag_next = crossing_flag;
    sync_count_next    = sync_count;
    r_commutated       = 1'b0;
    r_high             = '0;
    r_low              = '0;
    r_duty             = '0;
    r_written          = 1'b0;
    r_seen             = 1'b0;
    if (pop) begin
      if (q_entry.tick) begin
        r_commutated      = 1'b1;
        r_high            = ph.high;
        r_low             = ph.low;
        r_duty            = duty_sat;
        floating_now_next = ph.float_ph;
        next_stage_next   = (st >= LAST_STAGE) ? 3'd0 : st + 1'b1;
        case (mode)
          MODE_RAMP: begin
            ramp_period_next  = ramp_short;
            timer_reload_next = ramp_dec;
            r_written         = 1'b1;
            if (ramp_short < sync_period) begin
              mode_next       = MODE_SYNC;
              sync_count_next = '0;
            end
          end
          MODE_SYNC: begin
            crossing_flag_next = 1'b0;
            if (count_inc >= sync_crossings) begin
              sync_count_next = '0;
              mode_next       = MODE_CLOSED;
            end else begin
              sync_count_next = count_inc;
            end
          end
          default: ;
        endcase
      end else if (mode != MODE_RAMP && hit) begin
        r_seen = 1'b1;
        if (mode == MODE_SYNC) begin
          crossing_flag_next = 1'b1;
        end else begin
          crossing_flag_next = 1'b0;
          timer_reload_next  = np_dec;
          r_written          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_stage    <= '0;
      mode          <= MODE_RAMP;
      ramp_period   <= INIT_RST;
      timer_reload  <= RELOAD_RST;
      floating_now  <= PHASE_U;
      crossing_flag <= 1'b0;
      sync_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      next_stage    <= next_stage_next;
      mode          <= mode_next;
      ramp_period   <= ramp_period_next;
      timer_reload  <= timer_reload_next;
      floating_now  <= floating_now_next;
      crossing_flag <= crossing_flag_next;
      sync_count    <= sync_count_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      commutated     <= r_commutated;
      high_phase     <= r_high;
      low_phase      <= r_low;
      float_phase    <= floating_now_next;
      duty_out       <= r_duty;
      reload_value   <= timer_reload_next;
      reload_written <= r_written;
      mode_out       <= mode_next;
      crossing_seen  <= r_seen;
    end
  end

  a_closed_holds: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_CLOSED |=> mode == MODE_CLOSED)
    else $error("closed loop mode left");

  a_ramp_clean: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_RAMP |-> (sync_count == '0 && !crossing_flag))
    else $error("crossing state set during ramp");

  a_closed_no_flag: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_CLOSED |-> !crossing_flag)
    else $error("sticky crossing flag set in closed loop");

  a_stage_range: assert property (@(posedge clk) disable iff (rst)
    pop |=> next_stage <= LAST_STAGE)
    else $error("stage counter out of range");

endmodule

`default_nettype wire

[rtl/sensorless_six_step_commutator.sv]
`default_nettype none

// Channel   Dir  Handshake           Contents
// s_axis    in   s_tvalid/s_tready   tuser req_type; tdata bemf u, v, w raw
// m_axis    out  m_tvalid/m_tready   tuser commutated; tdata phases, duty,
//                                    reload, written flag, mode, crossing
// cfg       in   cfg_wen             cfg_index selects register, cfg_data value
//
// One word per cycle sustained in both directions while neither side stalls.
// A word passes the front compare register, the two-entry queue and the result register
// in that order before it leaves.
// Reset is synchronous; all configuration registers and motor state take their defaults.
// Either side may stall; the queue absorbs up to two words behind a stalled output.

module sensorless_six_step_commutator #(
  parameter int PERIOD_BITS = 18,
  parameter int ADC_BITS    = 12
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // bemf_u_raw, bemf_v_raw, bemf_w_raw, zero pad
  input  wire logic [((3*ADC_BITS+7)/8)*8-1:0] s_tdata,
  // req_type
  input  wire logic                s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // high_phase, low_phase, float_phase, duty_out, reload_value,
  // reload_written, mode_out, crossing_seen, zero pad
  output logic [((15+PERIOD_BITS+7)/8)*8-1:0] m_tdata,
  // commutated
  output logic                     m_tuser,
  input  wire logic                cfg_wen,
  input  wire logic [sssc_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  wire logic [((PERIOD_BITS > 16) ? PERIOD_BITS : 16)-1:0] cfg_data
);
  import sssc_pkg::*;

  localparam int OUT_W = ((15+PERIOD_BITS+7)/8)*8;

  logic [PERIOD_BITS-1:0] initial_period, min_period, sync_period;
  logic [15:0]            ramp_step;
  logic [ADC_BITS-1:0]    bemf_threshold;
  logic [4:0]             drive_compare;
  logic [3:0]             sync_crossings;

  logic                   f_valid, f_ready;
  qent_t                  f_entry;
  logic                   b_valid, b_ready;
  qent_t                  b_entry;

  logic                   commutated, reload_written, crossing_seen;
  logic [1:0]             high_phase, low_phase, float_phase;
  logic [4:0]             duty_out;
  logic [PERIOD_BITS-1:0] reload_value;
  mode_t                  mode_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_period <= PERIOD_BITS'(DEF_INITIAL_PERIOD);
      ramp_step      <= DEF_RAMP_STEP;
      min_period     <= PERIOD_BITS'(DEF_MIN_PERIOD);
      sync_period    <= PERIOD_BITS'(DEF_SYNC_PERIOD);
      bemf_threshold <= ADC_BITS'(DEF_BEMF_THRESHOLD);
      drive_compare  <= DEF_DRIVE_COMPARE;
      sync_crossings <= DEF_SYNC_CROSSINGS;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_INITIAL_PERIOD: initial_period <= cfg_data[PERIOD_BITS-1:0];
        REG_RAMP_STEP:      ramp_step      <= cfg_data[15:0];
        REG_MIN_PERIOD:     min_period     <= cfg_data[PERIOD_BITS-1:0];
        REG_SYNC_PERIOD:    sync_period    <= cfg_data[PERIOD_BITS-1:0];
        REG_BEMF_THRESHOLD: bemf_threshold <= cfg_data[ADC_BITS-1:0];
        REG_DRIVE_COMPARE:  drive_compare  <= cfg_data[4:0];
        REG_SYNC_CROSSINGS: sync_crossings <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  sssc_front #(
    .ADC_BITS(ADC_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .req_type      (s_tuser),
    .bemf_u_raw    (s_tdata[ADC_BITS-1:0]),
    .bemf_v_raw    (s_tdata[2*ADC_BITS-1:ADC_BITS]),
    .bemf_w_raw    (s_tdata[3*ADC_BITS-1:2*ADC_BITS]),
    .bemf_threshold(bemf_threshold),
    .q_valid       (f_valid),
    .q_ready       (f_ready),
    .q_entry       (f_entry)
  );

  sssc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_entry (f_entry),
    .out_valid(b_valid),
    .out_ready(b_ready),
    .out_entry(b_entry)
  );

  sssc_back #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .min_period    (min_period),
    .sync_period   (sync_period),
    .ramp_step     (ramp_step),
    .drive_compare (drive_compare),
    .sync_crossings(sync_crossings),
    .q_valid       (b_valid),
    .q_ready       (b_ready),
    .q_entry       (b_entry),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .commutated    (commutated),
    .high_phase    (high_phase),
    .low_phase     (low_phase),
    .float_phase   (float_phase),
    .duty_out      (duty_out),
    .reload_value  (reload_value),
    .reload_written(reload_written),
    .mode_out      (mode_out),
    .crossing_seen (crossing_seen)
  );

  // initial_period is written by cfg but unused; the back end seeds its reset state from DEF_INITIAL_PERIOD
  logic unused_initial;
  assign unused_initial = ^initial_period;

  assign m_tuser = commutated;
  assign m_tdata = OUT_W'({crossing_seen, mode_out, reload_written, reload_value,
                           duty_out, float_phase, low_phase, high_phase});

endmodule

`default_nettype wire
